// ----- rtl/ezs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezs_pkg
// Shared types, register indexes and exp tables of the EWMA z-score scorer.
// ----------------------------------------------------------------------------
package ezs_pkg;

    localparam int CHANNELS = 6;
    localparam int CH_W     = $clog2(CHANNELS);

    localparam logic [31:0] W_MAX1  = 32'd45875;
    localparam logic [31:0] W_MAX2  = 32'd19661;
    localparam logic [63:0] EPS_Q32 = 64'd43;

    localparam logic [7:0] REG_MIN_SAMPLES = 8'd0;
    localparam logic [7:0] REG_ALPHA       = 8'd1;
    localparam logic [7:0] REG_WARNING     = 8'd2;
    localparam logic [7:0] REG_ALARM       = 8'd3;

    typedef enum logic [1:0] {
        LVL_NORMAL  = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_ALARM   = 2'd2
    } t_level;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_SQRT, S_DIV, S_EXP1, S_EXP2, S_EXP3, S_EXP4, S_MAX,
        S_CMB1, S_CMB2, S_CMB3, S_UPD, S_ADIV, S_U1, S_U2, S_U3, S_U4, S_U5,
        S_U6, S_U7, S_U8, S_U9, S_UNEXT, S_DONE
    } t_state;

    // exp(-k/16) in Q1.16, k = 0..16
    function automatic logic [16:0] exp_frac(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            5'd16:   v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-n) in Q1.16, n = 0..11
    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/ezs_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezs_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ezs_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- rtl/ezs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezs_div
// Restoring divider, 48-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module ezs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [47:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [47:0] r_quot;
    logic [31:0] r_dvs;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        take;

    assign rem_sh = {r_rem, r_quot[47]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign take   = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= take ? diff[31:0] : rem_sh[31:0];
            r_quot <= {r_quot[46:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/ezs_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezs_sqrt
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module ezs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;

    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
            r_root <= {r_root[30:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/ewma_zscore_anomaly_scorer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewma_zscore_anomaly_scorer_unit
// Per-channel EWMA baselines, z-score, exp squash and max-of-two combine,
// sequenced over one shared multiplier, a divider and a square root unit.
// ----------------------------------------------------------------------------
// Per item: channels in warm-up skip scoring; each scored channel runs the
// square root, the divide and, unless z is at most one or saturates, the
// exp squash; the two maxima are combined; unless the level is alarm, each
// baseline is updated (alpha divide in warm-up, a seed for a first sample).
// One item at a time, input stalled meanwhile and during output stall.
// Reset clears baselines, counts and restores register defaults at once.
module ewma_zscore_anomaly_scorer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_temperature,
    input  logic [31:0] i_temperature_slope,
    input  logic [31:0] i_vibration_rms,
    input  logic [31:0] i_vibration_band,
    input  logic [31:0] i_audio_rms,
    input  logic [31:0] i_audio_band,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_combined_score,
    output logic [1:0]  o_level,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [ezs_pkg::CH_W-1:0] LAST_CH = ezs_pkg::CH_W'(ezs_pkg::CHANNELS - 1);

    ezs_pkg::t_state r_state, n_state;

    logic [15:0] r_min;
    logic [15:0] r_alpha_cfg;
    logic [15:0] r_warn;
    logic [15:0] r_alarm;

    logic signed [31:0] r_x    [ezs_pkg::CHANNELS];
    logic signed [31:0] r_mean [ezs_pkg::CHANNELS];
    logic [63:0]        r_var  [ezs_pkg::CHANNELS];
    logic [15:0]        r_cnt  [ezs_pkg::CHANNELS];

    logic [ezs_pkg::CH_W-1:0] r_ch;
    logic [31:0] r_mag;
    logic        r_neg;
    logic [3:0]  r_n;
    logic [15:0] r_f;
    logic [16:0] r_ef;
    logic [15:0] r_cs;
    logic [15:0] r_max1;
    logic [15:0] r_max2;
    logic [63:0] r_acc;
    logic [63:0] r_d2;
    logic [63:0] r_s;
    logic [16:0] r_alpha;
    logic [15:0] r_score;
    logic [1:0]  r_lvl;
    logic        r_ovalid;
    logic [15:0] r_oscore;
    logic [1:0]  r_olvl;

    // current channel view
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_mean;
    logic [63:0]        cur_var;
    logic [15:0]        cur_cnt;
    logic signed [32:0] delta;
    logic [32:0]        mag33;
    logic [16:0]        cnt_p1;
    logic [16:0]        w_keep;

    assign cur_x    = r_x[r_ch];
    assign cur_mean = r_mean[r_ch];
    assign cur_var  = r_var[r_ch];
    assign cur_cnt  = r_cnt[r_ch];
    assign delta    = {cur_x[31], cur_x} - {cur_mean[31], cur_mean};
    assign mag33    = delta[32] ? 33'(-delta) : 33'(delta);
    assign cnt_p1   = {1'b0, cur_cnt} + 17'd1;
    assign w_keep   = 17'd65536 - r_alpha;

    // shared units
    logic        sq_start, sq_done;
    logic [63:0] sq_rad;
    logic [31:0] sq_root;
    logic        dv_start, dv_done;
    logic [47:0] dv_dividend, dv_quot;
    logic [31:0] dv_divisor;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    ezs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    ezs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (dv_dividend),
        .i_divisor  (dv_divisor),
        .o_done     (dv_done),
        .o_quot     (dv_quot)
    );

    ezs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // derived values
    logic        skip_score;
    logic [46:0] t_val;
    logic [4:0]  f_idx;
    logic [16:0] tab_lo;
    logic [16:0] tab_hi;
    logic [31:0] interp;
    logic [33:0] e_rnd;
    logic [16:0] e_val;
    logic [32:0] cmb_sum;
    logic [16:0] cmb;
    logic [15:0] score_c;
    logic [1:0]  lvl_c;
    logic [48:0] r_rnd;
    logic [32:0] mean_n;
    logic [63:0] m_q;
    logic [64:0] s_sum;

    assign skip_score = (cur_cnt < r_min);
    assign t_val      = 47'((dv_quot - 48'd65536) >> 1);
    assign f_idx      = {1'b0, r_f[15:12]};
    assign tab_lo     = ezs_pkg::exp_frac(f_idx);
    assign tab_hi     = ezs_pkg::exp_frac(f_idx + 5'd1);
    assign interp     = (mul_p[31:0] + 32'd2048) >> 12;
    assign e_rnd      = (mul_p[33:0] + 34'd32768) >> 16;
    assign e_val      = e_rnd[16:0];
    assign cmb_sum    = r_acc[32:0] + mul_p[32:0] + 33'd32768;
    assign cmb        = cmb_sum[32:16];
    assign score_c    = cmb[16] ? 16'hFFFF : cmb[15:0];
    assign lvl_c      = (score_c >= r_alarm) ? ezs_pkg::LVL_ALARM :
                        (score_c >= r_warn)  ? ezs_pkg::LVL_WARNING :
                                               ezs_pkg::LVL_NORMAL;
    assign r_rnd      = (mul_p[48:0] + 49'd32768) >> 16;
    assign mean_n     = r_neg ? ({cur_mean[31], cur_mean} - {1'b0, r_rnd[31:0]})
                              : ({cur_mean[31], cur_mean} + {1'b0, r_rnd[31:0]});
    assign m_q        = (r_acc << 16) + (mul_p >> 16);
    assign s_sum      = {1'b0, cur_var} + {1'b0, m_q};

    // sequencer
    always_comb begin
        n_state     = r_state;
        sq_start    = 1'b0;
        sq_rad      = (cur_var < ezs_pkg::EPS_Q32) ? ezs_pkg::EPS_Q32 : cur_var;
        dv_start    = 1'b0;
        dv_dividend = {r_mag, 16'h0000};
        dv_divisor  = sq_root;
        mul_a       = '0;
        mul_b       = '0;
        case (r_state)
            ezs_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ezs_pkg::S_CHK;
            end
            ezs_pkg::S_CHK: begin
                if (skip_score) begin
                    n_state = ezs_pkg::S_MAX;
                end else begin
                    sq_start = 1'b1;
                    n_state  = ezs_pkg::S_SQRT;
                end
            end
            ezs_pkg::S_SQRT: begin
                if (sq_done) begin
                    dv_start = 1'b1;
                    n_state  = ezs_pkg::S_DIV;
                end
            end
            ezs_pkg::S_DIV: begin
                if (dv_done) begin
                    if (dv_quot <= 48'd65536 || t_val[46:16] >= 31'd12) begin
                        n_state = ezs_pkg::S_MAX;
                    end else begin
                        n_state = ezs_pkg::S_EXP1;
                    end
                end
            end
            ezs_pkg::S_EXP1: begin
                mul_a   = {15'd0, tab_lo - tab_hi};
                mul_b   = {20'd0, r_f[11:0]};
                n_state = ezs_pkg::S_EXP2;
            end
            ezs_pkg::S_EXP2: n_state = ezs_pkg::S_EXP3;
            ezs_pkg::S_EXP3: begin
                mul_a   = {15'd0, ezs_pkg::exp_int(r_n)};
                mul_b   = {15'd0, r_ef};
                n_state = ezs_pkg::S_EXP4;
            end
            ezs_pkg::S_EXP4: n_state = ezs_pkg::S_MAX;
            ezs_pkg::S_MAX: begin
                n_state = (r_ch == LAST_CH) ? ezs_pkg::S_CMB1 : ezs_pkg::S_CHK;
            end
            ezs_pkg::S_CMB1: begin
                mul_a   = ezs_pkg::W_MAX1;
                mul_b   = {16'd0, r_max1};
                n_state = ezs_pkg::S_CMB2;
            end
            ezs_pkg::S_CMB2: begin
                mul_a   = ezs_pkg::W_MAX2;
                mul_b   = {16'd0, r_max2};
                n_state = ezs_pkg::S_CMB3;
            end
            ezs_pkg::S_CMB3: begin
                n_state = (lvl_c == ezs_pkg::LVL_ALARM) ? ezs_pkg::S_DONE : ezs_pkg::S_UPD;
            end
            ezs_pkg::S_UPD: begin
                if (cur_cnt == 16'd0) begin
                    n_state = ezs_pkg::S_UNEXT;
                end else if (skip_score) begin
                    dv_start    = 1'b1;
                    dv_dividend = 48'(17'd65536 + (cnt_p1 >> 1));
                    dv_divisor  = 32'(cnt_p1);
                    n_state     = ezs_pkg::S_ADIV;
                end else begin
                    n_state = ezs_pkg::S_U1;
                end
            end
            ezs_pkg::S_ADIV: begin
                if (dv_done) n_state = ezs_pkg::S_U1;
            end
            ezs_pkg::S_U1: begin
                mul_a   = r_mag;
                mul_b   = 32'(r_alpha);
                n_state = ezs_pkg::S_U2;
            end
            ezs_pkg::S_U2: begin
                mul_a   = r_mag;
                mul_b   = r_mag;
                n_state = ezs_pkg::S_U3;
            end
            ezs_pkg::S_U3: n_state = ezs_pkg::S_U4;
            ezs_pkg::S_U4: begin
                mul_a   = r_d2[63:32];
                mul_b   = 32'(r_alpha);
                n_state = ezs_pkg::S_U5;
            end
            ezs_pkg::S_U5: begin
                mul_a   = r_d2[31:0];
                mul_b   = 32'(r_alpha);
                n_state = ezs_pkg::S_U6;
            end
            ezs_pkg::S_U6: n_state = ezs_pkg::S_U7;
            ezs_pkg::S_U7: begin
                mul_a   = r_s[63:32];
                mul_b   = 32'(w_keep);
                n_state = ezs_pkg::S_U8;
            end
            ezs_pkg::S_U8: begin
                mul_a   = r_s[31:0];
                mul_b   = 32'(w_keep);
                n_state = ezs_pkg::S_U9;
            end
            ezs_pkg::S_U9: n_state = ezs_pkg::S_UNEXT;
            ezs_pkg::S_UNEXT: begin
                n_state = (r_ch == LAST_CH) ? ezs_pkg::S_DONE : ezs_pkg::S_UPD;
            end
            ezs_pkg::S_DONE: begin
                if (!r_ovalid || !i_out_stall) n_state = ezs_pkg::S_IDLE;
            end
            default: n_state = ezs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ezs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= 16'd32;
            r_alpha_cfg <= 16'd655;
            r_warn      <= 16'd32768;
            r_alarm     <= 16'd52429;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ezs_pkg::REG_MIN_SAMPLES: r_min       <= i_cfg_data;
                ezs_pkg::REG_ALPHA:       r_alpha_cfg <= i_cfg_data;
                ezs_pkg::REG_WARNING:     r_warn      <= i_cfg_data;
                ezs_pkg::REG_ALARM:       r_alarm     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-channel baselines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ezs_pkg::CHANNELS; i++) begin
                r_mean[i] <= '0;
                r_var[i]  <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            case (r_state)
                ezs_pkg::S_UPD: begin
                    if (cur_cnt == 16'd0) begin
                        r_mean[r_ch] <= cur_x;
                        r_var[r_ch]  <= '0;
                        r_cnt[r_ch]  <= 16'd1;
                    end
                end
                ezs_pkg::S_U2: r_mean[r_ch] <= mean_n[31:0];
                ezs_pkg::S_U9: begin
                    r_var[r_ch] <= m_q;
                    if (cur_cnt != 16'hFFFF) r_cnt[r_ch] <= cur_cnt + 16'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && r_state != ezs_pkg::S_DONE) r_ovalid <= 1'b0;
            case (r_state)
                ezs_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_x[0] <= i_temperature;
                        r_x[1] <= i_temperature_slope;
                        r_x[2] <= i_vibration_rms;
                        r_x[3] <= i_vibration_band;
                        r_x[4] <= i_audio_rms;
                        r_x[5] <= i_audio_band;
                        r_ch   <= '0;
                        r_max1 <= '0;
                        r_max2 <= '0;
                    end
                end
                ezs_pkg::S_CHK: begin
                    r_mag <= mag33[31:0];
                    r_cs  <= '0;
                end
                ezs_pkg::S_DIV: begin
                    if (dv_done) begin
                        r_n <= t_val[19:16];
                        r_f <= t_val[15:0];
                        if (dv_quot > 48'd65536 && t_val[46:16] >= 31'd12) r_cs <= 16'hFFFF;
                    end
                end
                ezs_pkg::S_EXP2: r_ef <= tab_lo - interp[16:0];
                ezs_pkg::S_EXP4: begin
                    if (e_val >= 17'd65536) r_cs <= '0;
                    else if (e_val == 17'd0) r_cs <= 16'hFFFF;
                    else r_cs <= 16'(17'd65536 - e_val);
                end
                ezs_pkg::S_MAX: begin
                    // a tie does not displace the current maximum
                    if (r_cs > r_max1) begin
                        r_max2 <= r_max1;
                        r_max1 <= r_cs;
                    end else if (r_cs > r_max2) begin
                        r_max2 <= r_cs;
                    end
                    if (r_ch != LAST_CH) r_ch <= r_ch + 1'b1;
                end
                ezs_pkg::S_CMB2: r_acc <= mul_p;
                ezs_pkg::S_CMB3: begin
                    r_score <= score_c;
                    r_lvl   <= lvl_c;
                    r_ch    <= '0;
                end
                ezs_pkg::S_UPD: begin
                    r_mag   <= mag33[31:0];
                    r_neg   <= delta[32];
                    r_alpha <= {1'b0, r_alpha_cfg};
                end
                ezs_pkg::S_ADIV: begin
                    if (dv_done) r_alpha <= dv_quot[16:0];
                end
                ezs_pkg::S_U3: r_d2 <= mul_p;
                ezs_pkg::S_U5: r_acc <= mul_p;
                ezs_pkg::S_U6: r_s <= s_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_sum[63:0];
                ezs_pkg::S_U8: r_acc <= mul_p;
                ezs_pkg::S_UNEXT: begin
                    if (r_ch != LAST_CH) r_ch <= r_ch + 1'b1;
                end
                ezs_pkg::S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_oscore <= r_score;
                        r_olvl   <= r_lvl;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall       = (r_state != ezs_pkg::S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_ovalid;
    assign o_combined_score = r_oscore;
    assign o_level          = r_olvl;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EWMA z-score anomaly scorer testbench
// Drives sensor snapshots and register writes into the scorer, predicts the
// combined score and level of every accepted snapshot with an independent
// bit-accurate model of the baselines, and checks each result beat in order,
// against the typed result where a directed row gives one. A directed table
// covers extremes and corner settings; random phases follow with noise and
// spikes around a fixed centre, under random gaps and stalls but in calm phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          NCH          = ezs_pkg::CHANNELS;
    localparam logic [7:0]  REG_SPARE_LO = 8'd4;
    localparam logic [7:0]  REG_SPARE_HI = 8'hFF;
    localparam int          WATCH_LIMIT  = 20000;

    typedef logic [NCH-1:0][31:0] t_snap;

    typedef struct {
        bit              is_cfg;
        logic [7:0]      idx;
        logic [15:0]     data;
        t_snap           xs;
        bit              typed;
        logic [15:0]     score;
        ezs_pkg::t_level lvl;
    } t_row;

    typedef struct {
        logic [15:0]     score;
        ezs_pkg::t_level lvl;
    } t_grade;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_snap       snap = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_combined_score;
    logic [1:0]  o_level;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    ewma_zscore_anomaly_scorer_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_temperature       (snap[0]),
        .i_temperature_slope (snap[1]),
        .i_vibration_rms     (snap[2]),
        .i_vibration_band    (snap[3]),
        .i_audio_rms         (snap[4]),
        .i_audio_band        (snap[5]),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_combined_score    (o_combined_score),
        .o_level             (o_level),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Baseline model
    // ------------------------------------------------------------------
    int unsigned frac_lut [17] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                   42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                   27319, 25664, 24109};
    int unsigned int_lut [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
                                  8, 3, 1};

    longint      base_mean [NCH];
    logic [63:0] base_var  [NCH];
    int unsigned base_cnt  [NCH];
    int unsigned warmup_len = 32;
    int unsigned ewma_alpha = 655;
    int unsigned warn_thr   = 32768;
    int unsigned alarm_thr  = 52429;

    initial begin
        for (int c = 0; c < NCH; c++) begin
            base_mean[c] = 0;
            base_var[c]  = '0;
            base_cnt[c]  = 0;
        end
    end

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    // floor(v * w / 65536), upper part wraps before the saturating sum
    function automatic logic [63:0] weigh_q16(input logic [63:0] v, input logic [16:0] w);
        logic [63:0] hi, lo, wide;
        wide = {47'd0, w};
        hi   = (v >> 32) * wide;
        lo   = ((v & 64'hFFFF_FFFF) * wide) >> 16;
        return sat_sum(hi << 16, lo);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res, b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] channel_grade(input int c, input longint x);
        longint      d;
        logic [63:0] mag, vr, sigma, z, t, n, f, idx, rem, ef, e;
        if (base_cnt[c] < warmup_len) return 16'd0;
        d   = x - base_mean[c];
        mag = (d < 0) ? 64'(-d) : 64'(d);
        vr  = (base_var[c] < ezs_pkg::EPS_Q32) ? ezs_pkg::EPS_Q32 : base_var[c];
        sigma = root64(vr);
        z = (mag << 16) / sigma;
        if (z <= 64'd65536) return 16'd0;
        t = (z - 64'd65536) >> 1;
        n = t >> 16;
        if (n >= 12) return 16'hFFFF;
        f   = t & 64'hFFFF;
        idx = f >> 12;
        rem = f & 64'hFFF;
        ef  = 64'(frac_lut[idx]) -
              (((64'(frac_lut[idx]) - 64'(frac_lut[idx + 1])) * rem + 64'd2048) >> 12);
        e   = (64'(int_lut[n]) * ef + 64'd32768) >> 16;
        if (e >= 64'd65536) return 16'd0;
        if (e == 0) return 16'hFFFF;
        return 16'(64'd65536 - e);
    endfunction

    function automatic void baseline_advance(input int c, input longint x);
        longint      d;
        logic [63:0] mag, r, d2, s;
        logic [16:0] alpha;
        int unsigned cnt;
        cnt = base_cnt[c];
        if (cnt == 0) begin
            base_mean[c] = x;
            base_var[c]  = '0;
            base_cnt[c]  = 1;
            return;
        end
        d = x - base_mean[c];
        if (cnt < warmup_len) alpha = 17'((65536 + (cnt + 1) / 2) / (cnt + 1));
        else                  alpha = 17'(ewma_alpha);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        r   = (mag * {47'd0, alpha} + 64'd32768) >> 16;
        base_mean[c] = (d < 0) ? base_mean[c] - longint'(r) : base_mean[c] + longint'(r);
        d2  = mag * mag;
        s   = sat_sum(base_var[c], weigh_q16(d2, alpha));
        base_var[c] = weigh_q16(s, 17'd65536 - alpha);
        if (cnt < 65535) base_cnt[c] = cnt + 1;
    endfunction

    function automatic t_grade grade_snapshot(input t_snap xs);
        t_grade      g;
        int unsigned m1, m2, s, sc;
        longint      xv [NCH];
        m1 = 0;
        m2 = 0;
        for (int c = 0; c < NCH; c++) begin
            xv[c] = longint'($signed(xs[c]));
            s = 32'(channel_grade(c, xv[c]));
            if (s > m1) begin
                m2 = m1;
                m1 = s;
            end else if (s > m2) begin
                m2 = s;
            end
        end
        sc = int'((64'd45875 * m1 + 64'd19661 * m2 + 64'd32768) >> 16);
        if (sc > 65535) sc = 65535;
        g.score = 16'(sc);
        if (sc >= alarm_thr)     g.lvl = ezs_pkg::LVL_ALARM;
        else if (sc >= warn_thr) g.lvl = ezs_pkg::LVL_WARNING;
        else                     g.lvl = ezs_pkg::LVL_NORMAL;
        if (g.lvl != ezs_pkg::LVL_ALARM) begin
            for (int c = 0; c < NCH; c++) baseline_advance(c, xv[c]);
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check result beats, predict accepted snapshots, track writes
    // ------------------------------------------------------------------
    t_grade      pending_grades [$];
    bit          failed = 1'b0;
    int unsigned in_beats = 0;
    int unsigned cfg_beats = 0;
    int unsigned idle_cycles = 0;
    bit          row_typed = 1'b0;
    t_grade      row_grade;

    always @(posedge i_clk) begin
        t_grade want, pred;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_grades.size() == 0) begin
                    $error("unexpected result beat: combined_score %0d level %0d",
                           o_combined_score, o_level);
                    failed = 1'b1;
                end else begin
                    want = pending_grades.pop_front();
                    if (o_combined_score !== want.score) begin
                        $error("combined_score expected %0d actual %0d",
                               want.score, o_combined_score);
                        failed = 1'b1;
                    end
                    if (o_level !== want.lvl) begin
                        $error("level expected %0d actual %0d", want.lvl, o_level);
                        failed = 1'b1;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                pred = grade_snapshot(snap);
                pending_grades.push_back(row_typed ? row_grade : pred);
                in_beats++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    ezs_pkg::REG_MIN_SAMPLES: warmup_len = 32'(i_cfg_data);
                    ezs_pkg::REG_ALPHA:       ewma_alpha = 32'(i_cfg_data);
                    ezs_pkg::REG_WARNING:     warn_thr   = 32'(i_cfg_data);
                    ezs_pkg::REG_ALARM:       alarm_thr  = 32'(i_cfg_data);
                    default: ;
                endcase
                cfg_beats++;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Back-pressure on the result side
    // ------------------------------------------------------------------
    bit calm = 1'b0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        int n;
        forever begin
            n = calm ? 0 : gap_len();
            if (n > 0) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    t_row plan [$];

    function automatic void plan_cfg(input logic [7:0] idx, input logic [15:0] data);
        t_row r;
        r = '{lvl: ezs_pkg::LVL_NORMAL, default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        plan.push_back(r);
    endfunction

    function automatic void plan_snap(input logic [31:0] v, input bit typed,
                                      input logic [15:0] sc, input ezs_pkg::t_level lv);
        t_row r;
        r = '{lvl: ezs_pkg::LVL_NORMAL, default: '0};
        for (int c = 0; c < NCH; c++) r.xs[c] = v;
        r.typed = typed;
        r.score = sc;
        r.lvl   = lv;
        plan.push_back(r);
    endfunction

    task automatic drain_results();
        while (pending_grades.size() != 0) @(negedge i_clk);
        repeat ($urandom_range(1, 4)) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        int unsigned seen;
        seen = cfg_beats;
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (cfg_beats == seen);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_snap(input t_snap xs, input bit typed, input t_grade g);
        int unsigned seen;
        int          n;
        n = calm ? 0 : gap_len();
        if (n > 0) repeat (n) @(negedge i_clk);
        seen      = in_beats;
        row_typed = typed;
        row_grade = g;
        snap      = xs;
        i_in_valid = 1'b1;
        do @(negedge i_clk); while (in_beats == seen);
        i_in_valid = 1'b0;
        row_typed  = 1'b0;
    endtask

    function automatic logic [15:0] pick16(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return 16'(lo);
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    initial begin
        t_grade      g;
        t_snap       xs;
        int          centre [NCH];
        int unsigned spread;
        int          k;
        logic [15:0] w, a;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // warm-up after reset scores nothing
        plan_snap(32'h0000_0000, 1'b1, 16'd0, ezs_pkg::LVL_NORMAL);
        // zero warm-up: extremes against a zero baseline saturate every channel
        plan_cfg(ezs_pkg::REG_MIN_SAMPLES, 16'd0);
        plan_snap(32'h7FFF_FFFF, 1'b1, 16'hFFFF, ezs_pkg::LVL_ALARM);
        plan_snap(32'h8000_0000, 1'b1, 16'hFFFF, ezs_pkg::LVL_ALARM);
        plan_cfg(ezs_pkg::REG_ALARM, 16'hFFFF);
        plan_cfg(ezs_pkg::REG_WARNING, 16'd0);
        plan_snap(32'h8000_0000, 1'b1, 16'hFFFF, ezs_pkg::LVL_ALARM);
        plan_snap(32'h0000_0000, 1'b1, 16'd0, ezs_pkg::LVL_WARNING);
        // frozen baseline, then full-weight baseline
        plan_cfg(ezs_pkg::REG_ALPHA, 16'd0);
        plan_snap(32'h0001_0000, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        plan_snap(32'hFFFF_0000, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        plan_cfg(ezs_pkg::REG_ALPHA, 16'hFFFF);
        plan_snap(32'h0002_8000, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        plan_snap(32'h0002_8001, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        // writes past the last register are dropped
        plan_cfg(REG_SPARE_LO, 16'd1234);
        plan_cfg(REG_SPARE_HI, 16'd1);
        // crossed thresholds
        plan_cfg(ezs_pkg::REG_WARNING, 16'd60000);
        plan_cfg(ezs_pkg::REG_ALARM, 16'd1000);
        plan_cfg(ezs_pkg::REG_MIN_SAMPLES, 16'd4);
        plan_cfg(ezs_pkg::REG_ALPHA, 16'd8000);
        plan_snap(32'h0003_0000, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        plan_snap(32'h0003_4000, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        plan_snap(32'h7FFF_FFFF, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        plan_cfg(ezs_pkg::REG_WARNING, 16'd32768);
        plan_cfg(ezs_pkg::REG_ALARM, 16'd52429);
        plan_snap(32'h0003_2000, 1'b0, '0, ezs_pkg::LVL_NORMAL);
        plan_snap(32'h8000_0000, 1'b0, '0, ezs_pkg::LVL_NORMAL);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_results();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                g.score = plan[i].score;
                g.lvl   = plan[i].lvl;
                send_snap(plan[i].xs, plan[i].typed, g);
            end
        end

        // random phases: fresh settings, signals around a random centre with spikes and noise
        for (int ph = 0; ph < 11; ph++) begin
            drain_results();
            calm = (ph % 4 == 1);
            case ($urandom_range(0, 7))
                0:       write_reg(ezs_pkg::REG_MIN_SAMPLES, 16'd0);
                1:       write_reg(ezs_pkg::REG_MIN_SAMPLES, 16'hFFFF);
                2:       write_reg(ezs_pkg::REG_MIN_SAMPLES, 16'd1);
                default: write_reg(ezs_pkg::REG_MIN_SAMPLES, 16'($urandom_range(2, 40)));
            endcase
            write_reg(ezs_pkg::REG_ALPHA, pick16(0, 20000));
            w = pick16(0, 65535);
            a = ($urandom_range(0, 3) == 0) ? pick16(0, 65535) : 16'($urandom_range(w, 65535));
            write_reg(ezs_pkg::REG_WARNING, w);
            write_reg(ezs_pkg::REG_ALARM, a);
            spread = 1 << $urandom_range(4, 20);
            for (int c = 0; c < NCH; c++) centre[c] = int'($urandom_range(0, 32'h0FFF_FFFF))
                                                        - 32'sh0800_0000;
            for (int i = 0; i < 50; i++) begin
                k = $urandom_range(0, 99);
                for (int c = 0; c < NCH; c++) begin
                    if (k < 15)
                        xs[c] = $urandom();
                    else if ($urandom_range(0, 19) == 0)
                        xs[c] = 32'(centre[c] + int'($urandom_range(0, 32'h00FF_FFFF)));
                    else
                        xs[c] = 32'(centre[c] + int'($urandom_range(0, 2 * spread))
                                    - int'(spread));
                end
                send_snap(xs, 1'b0, g);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (200) @(negedge i_clk);
        if (!failed && pending_grades.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- ewma_zscore_anomaly_scorer_unit.f -----
rtl/ezs_pkg.sv
rtl/ezs_mul.sv
rtl/ezs_div.sv
rtl/ezs_sqrt.sv
rtl/ewma_zscore_anomaly_scorer_unit.sv
tb/testbench.sv
